### hw/rtl/utsc_pkg.sv
// shared types, constants and helpers for the utf-8 text statistics counter
package utsc_pkg;

	localparam int COUNT_BITS = 32;
	localparam int OUT_BITS   = 32;
	localparam int CP_BITS    = 21;

	localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

	// cjk ranges
	localparam logic [CP_BITS-1:0] EXT_A_LO  = CP_BITS'(24'h003400);
	localparam logic [CP_BITS-1:0] EXT_A_HI  = CP_BITS'(24'h004DBF);
	localparam logic [CP_BITS-1:0] UNIFIED_LO = CP_BITS'(24'h004E00);
	localparam logic [CP_BITS-1:0] UNIFIED_HI = CP_BITS'(24'h009FFF);
	localparam logic [CP_BITS-1:0] COMPAT_LO = CP_BITS'(24'h00F900);
	localparam logic [CP_BITS-1:0] COMPAT_HI = CP_BITS'(24'h00FAFF);
	localparam logic [CP_BITS-1:0] KANA_LO   = CP_BITS'(24'h003040);
	localparam logic [CP_BITS-1:0] KANA_HI   = CP_BITS'(24'h0030FF);
	localparam logic [CP_BITS-1:0] HANGUL_LO = CP_BITS'(24'h00AC00);
	localparam logic [CP_BITS-1:0] HANGUL_HI = CP_BITS'(24'h00D7AF);

	// ascii classes
	localparam logic [CP_BITS-1:0] CP_TAB     = CP_BITS'(8'h09);
	localparam logic [CP_BITS-1:0] CP_CR      = CP_BITS'(8'h0D);
	localparam logic [CP_BITS-1:0] CP_SPACE   = CP_BITS'(8'h20);
	localparam logic [CP_BITS-1:0] CP_APOS    = CP_BITS'(8'h27);
	localparam logic [CP_BITS-1:0] CP_HYPHEN  = CP_BITS'(8'h2D);
	localparam logic [CP_BITS-1:0] CP_DIGIT_LO = CP_BITS'(8'h30);
	localparam logic [CP_BITS-1:0] CP_DIGIT_HI = CP_BITS'(8'h39);
	localparam logic [CP_BITS-1:0] CP_UPPER_LO = CP_BITS'(8'h41);
	localparam logic [CP_BITS-1:0] CP_UPPER_HI = CP_BITS'(8'h5A);
	localparam logic [CP_BITS-1:0] CP_LOWER_LO = CP_BITS'(8'h61);
	localparam logic [CP_BITS-1:0] CP_LOWER_HI = CP_BITS'(8'h7A);

	// lead byte decode
	localparam logic [2:0] LEAD2_TAG = 3'b110;
	localparam logic [3:0] LEAD3_TAG = 4'b1110;
	localparam logic [1:0] PEND_NONE = 2'd0;
	localparam logic [1:0] PEND_ONE  = 2'd1;
	localparam logic [1:0] PEND_TWO  = 2'd2;
	localparam logic [1:0] PEND_THREE = 2'd3;

	typedef struct packed {
		logic space;
		logic word;
		logic cjk;
	} cp_class_t;

	function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
		return (&v) ? v : v + CNT_ONE;
	endfunction

endpackage

### hw/rtl/utf8_text_statistics_counter_unit.sv
// top level of the utf-8 text statistics counter: decode, classify and counters
// One byte of UTF-8 text enters per cycle unless the result side stalls, and each byte
// produces one result transaction. A byte passes an input register, then a single stage of
// decode, classification and saturating increment that writes the decoder state, the four
// counters and the completion flag; the counters themselves form the result register.
// Sustained rate is one byte per clock; the only limit is the result side stalling, which
// holds the input register and stalls the input channel.
module utf8_text_statistics_counter_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_stall,
	input  logic [7:0]  data_byte,
	input  logic        run_end,
	input  logic        clear_counts,
	output logic        result_valid,
	input  logic        result_stall,
	output logic        char_done,
	output logic [31:0] total_chars,
	output logic [31:0] visible_chars,
	output logic [31:0] cjk_chars,
	output logic [31:0] word_total
);

	logic       valid_s1;
	logic [7:0] data_s1;
	logic       last_s1;
	logic       clr_s1;

	logic [utsc_pkg::CP_BITS-1:0] partial_q;
	logic [1:0]                   pending_q;
	logic                         in_word_q;
	logic                         done_q;
	logic                         res_valid_q;
	logic [utsc_pkg::COUNT_BITS-1:0] char_cnt_q;
	logic [utsc_pkg::COUNT_BITS-1:0] vis_cnt_q;
	logic [utsc_pkg::COUNT_BITS-1:0] cjk_cnt_q;
	logic [utsc_pkg::COUNT_BITS-1:0] word_cnt_q;

	logic                         advance;
	logic [utsc_pkg::CP_BITS-1:0] point_d;
	logic [1:0]                   pending_d;
	logic                         done_d;
	utsc_pkg::cp_class_t          cls;
	logic [utsc_pkg::COUNT_BITS-1:0] char_base, vis_base, cjk_base, word_base;

	assign advance    = valid_s1 && (!res_valid_q || !result_stall);
	assign byte_stall = valid_s1 && !advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!byte_stall && byte_valid) begin
			data_s1 <= data_byte;
			last_s1 <= run_end;
			clr_s1  <= clear_counts;
		end
	end

	// utf-8 decode
	always_comb begin
		pending_d = utsc_pkg::PEND_NONE;
		done_d    = 1'b0;
		if (pending_q != utsc_pkg::PEND_NONE) begin
			point_d   = {partial_q[utsc_pkg::CP_BITS-7:0], data_s1[5:0]};
			pending_d = pending_q - utsc_pkg::PEND_ONE;
			done_d    = (pending_d == utsc_pkg::PEND_NONE);
		end else if (!data_s1[7]) begin
			point_d = utsc_pkg::CP_BITS'(data_s1);
			done_d  = 1'b1;
		end else if (data_s1[7:5] == utsc_pkg::LEAD2_TAG) begin
			point_d   = utsc_pkg::CP_BITS'(data_s1[4:0]);
			pending_d = utsc_pkg::PEND_ONE;
		end else if (data_s1[7:4] == utsc_pkg::LEAD3_TAG) begin
			point_d   = utsc_pkg::CP_BITS'(data_s1[3:0]);
			pending_d = utsc_pkg::PEND_TWO;
		end else begin
			point_d   = utsc_pkg::CP_BITS'(data_s1[2:0]);
			pending_d = utsc_pkg::PEND_THREE;
		end
		if (last_s1) begin
			done_d = 1'b1;
		end
	end

	utsc_classify u_classify (
		.code_point (point_d),
		.cls        (cls)
	);

	assign char_base = clr_s1 ? '0 : char_cnt_q;
	assign vis_base  = clr_s1 ? '0 : vis_cnt_q;
	assign cjk_base  = clr_s1 ? '0 : cjk_cnt_q;
	assign word_base = clr_s1 ? '0 : word_cnt_q;

	// decoder state, counters and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q   <= '0;
			pending_q   <= utsc_pkg::PEND_NONE;
			in_word_q   <= 1'b0;
			done_q      <= 1'b0;
			res_valid_q <= 1'b0;
			char_cnt_q  <= '0;
			vis_cnt_q   <= '0;
			cjk_cnt_q   <= '0;
			word_cnt_q  <= '0;
		end else begin
			if (!res_valid_q || !result_stall) begin
				res_valid_q <= valid_s1;
			end
			if (advance) begin
				done_q <= done_d;
				if (done_d) begin
					partial_q  <= '0;
					pending_q  <= utsc_pkg::PEND_NONE;
					in_word_q  <= cls.word && !last_s1;
					char_cnt_q <= utsc_pkg::sat_inc(char_base);
					vis_cnt_q  <= cls.space ? vis_base : utsc_pkg::sat_inc(vis_base);
					cjk_cnt_q  <= cls.cjk ? utsc_pkg::sat_inc(cjk_base) : cjk_base;
					word_cnt_q <= (cls.word && !in_word_q) ?
						utsc_pkg::sat_inc(word_base) : word_base;
				end else begin
					partial_q  <= point_d;
					pending_q  <= pending_d;
					in_word_q  <= in_word_q && !last_s1;
					char_cnt_q <= char_base;
					vis_cnt_q  <= vis_base;
					cjk_cnt_q  <= cjk_base;
					word_cnt_q <= word_base;
				end
			end
		end
	end

	assign result_valid  = res_valid_q;
	assign char_done     = done_q;
	assign total_chars   = utsc_pkg::OUT_BITS'(char_cnt_q);
	assign visible_chars = utsc_pkg::OUT_BITS'(vis_cnt_q);
	assign cjk_chars     = utsc_pkg::OUT_BITS'(cjk_cnt_q);
	assign word_total    = utsc_pkg::OUT_BITS'(word_cnt_q);

endmodule

### hw/rtl/utsc_classify.sv
// code point classifier: whitespace, english word character and cjk range
module utsc_classify (
	input  logic [utsc_pkg::CP_BITS-1:0] code_point,
	output utsc_pkg::cp_class_t          cls
);

	always_comb begin
		cls.space = (code_point == utsc_pkg::CP_SPACE) ||
			((code_point >= utsc_pkg::CP_TAB) && (code_point <= utsc_pkg::CP_CR));
		cls.word = ((code_point >= utsc_pkg::CP_DIGIT_LO) &&
				(code_point <= utsc_pkg::CP_DIGIT_HI)) ||
			((code_point >= utsc_pkg::CP_UPPER_LO) && (code_point <= utsc_pkg::CP_UPPER_HI)) ||
			((code_point >= utsc_pkg::CP_LOWER_LO) && (code_point <= utsc_pkg::CP_LOWER_HI)) ||
			(code_point == utsc_pkg::CP_APOS) || (code_point == utsc_pkg::CP_HYPHEN);
		cls.cjk = ((code_point >= utsc_pkg::EXT_A_LO) && (code_point <= utsc_pkg::EXT_A_HI)) ||
			((code_point >= utsc_pkg::UNIFIED_LO) && (code_point <= utsc_pkg::UNIFIED_HI)) ||
			((code_point >= utsc_pkg::COMPAT_LO) && (code_point <= utsc_pkg::COMPAT_HI)) ||
			((code_point >= utsc_pkg::KANA_LO) && (code_point <= utsc_pkg::KANA_HI)) ||
			((code_point >= utsc_pkg::HANGUL_LO) && (code_point <= utsc_pkg::HANGUL_HI));
	end

endmodule
